[sv/utf8dec_pkg.sv]
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Types and constants shared by the UTF-8 to UCS-2 decoder and its channels.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

	localparam int BYTE_W = 8;
	localparam int UNIT_W = 16;
	localparam int STAT_W = 2;
	localparam int PEND_W = 2;

	typedef logic [STAT_W-1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_LEAD = 2'd1;
	localparam status_t ST_TRUNC    = 2'd2;

	localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_KEEP  = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_KEEP  = 8'h0F;
	localparam logic [BYTE_W-1:0] CONT_KEEP   = 8'h3F;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		status_t           status;
		logic              final_res;
	} out_item_t;

endpackage

[sv/utf8dec_if.sv]
// ----------------------------------------------------------------------------
// utf8dec_if
// Valid/ready channels for source bytes and decoded code units.
// ----------------------------------------------------------------------------
interface utf8dec_in_if;
	import utf8dec_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface utf8dec_out_if;
	import utf8dec_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/utf8_to_ucs2_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Decodes a UTF-8 byte stream into UCS-2 code units, one byte per cycle unless the unit side stalls.
// ----------------------------------------------------------------------------
// channel       dir   payload                               transfer
// byte_stream   in    in_byte[8], end_of_stream[1]          valid && ready
// unit_stream   out   code_unit[16], status[2], final_res   valid && ready
//
// one byte per cycle sustained while the unit side keeps up; a taken byte's
// result passes through the input register, then the result register.
// reset clears the decode state and both stage valid flags.
// a stalled result only holds the pipe once both stages are full; bytes
// that produce no result still pass through the input register.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder (
	input  logic          clk,
	input  logic          arst_n,
	utf8dec_in_if.sink    byte_stream,
	utf8dec_out_if.source unit_stream
);
	import utf8dec_pkg::*;

	logic                valid_s1;
	in_item_t            item_s1;
	logic                valid_s2;
	out_item_t           res_s2;

	logic [PEND_W-1:0]   pending_q;
	logic [UNIT_W-1:0]   partial_q;
	logic                halted_q;

	logic                s2_free;
	logic                s1_free;
	logic                fire_s1;

	logic [PEND_W-1:0]   pending_d;
	logic [UNIT_W-1:0]   partial_d;
	logic                halted_d;
	logic                res_vld;
	out_item_t           res;
	logic [BYTE_W-1:0]   b;
	logic                eos;
	logic [UNIT_W-1:0]   shifted;
	logic [PEND_W-1:0]   pend_dec;

	assign s2_free = !valid_s2 || unit_stream.ready;
	assign s1_free = !valid_s1 || s2_free;
	assign fire_s1 = valid_s1 && s2_free;

	assign byte_stream.ready = s1_free;
	assign unit_stream.valid = valid_s2;
	assign unit_stream.data  = res_s2;

	assign b        = item_s1.in_byte;
	assign eos      = item_s1.end_of_stream;
	assign shifted  = {partial_q[UNIT_W-7:0], 6'b0} | UNIT_W'(b & CONT_KEEP);
	assign pend_dec = pending_q - PEND_W'(1);

	always_comb begin
		pending_d = pending_q;
		partial_d = partial_q;
		halted_d  = halted_q;
		res_vld   = 1'b0;
		res       = '{code_unit: '0, status: ST_OK, final_res: 1'b0};
		if (halted_q) begin
			if (eos) begin
				halted_d = 1'b0;
			end
		end else if (pending_q != '0) begin
			pending_d = pend_dec;
			partial_d = shifted;
			if (pend_dec == '0) begin
				partial_d = '0;
				res_vld   = 1'b1;
				res       = '{code_unit: shifted, status: ST_OK, final_res: eos};
			end else if (eos) begin
				pending_d = '0;
				partial_d = '0;
				res_vld   = 1'b1;
				res       = '{code_unit: '0, status: ST_TRUNC, final_res: 1'b1};
			end
		end else if (b < ASCII_LIMIT) begin
			res_vld = 1'b1;
			res     = '{code_unit: UNIT_W'(b), status: ST_OK, final_res: eos};
		end else if ((b & LEAD3_MASK) == LEAD3_MASK || (b & LEAD2_MASK) == LEAD2_MASK) begin
			if (eos) begin
				pending_d = '0;
				partial_d = '0;
				res_vld   = 1'b1;
				res       = '{code_unit: '0, status: ST_TRUNC, final_res: 1'b1};
			end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
				pending_d = PEND_W'(2);
				partial_d = UNIT_W'(b & LEAD3_KEEP);
			end else begin
				pending_d = PEND_W'(1);
				partial_d = UNIT_W'(b & LEAD2_KEEP);
			end
		end else begin
			pending_d = '0;
			partial_d = '0;
			halted_d  = !eos;
			res_vld   = 1'b1;
			res       = '{code_unit: '0, status: ST_BAD_LEAD, final_res: 1'b1};
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			item_s1 <= byte_stream.data;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			partial_q <= '0;
			halted_q  <= 1'b0;
		end else if (fire_s1) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
			halted_q  <= halted_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= fire_s1 && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			res_s2 <= res;
		end
	end

endmodule

[tb/tb_utf8_to_ucs2_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_ucs2_decoder
// Feeds the decoder a directed set of byte streams followed by random
// streams. Most random symbols are well formed: ASCII, 2-byte and 3-byte
// sequences. The rest hold stray continuation bytes, noise and cut-off
// sequences. Each accepted byte is decoded by a behavioral decoder kept in
// step with the block. Every code unit that comes out is checked field by
// field against the oldest decoded unit. Both channels idle in random bursts,
// and the unit side holds off once for a long stretch so the pipe fills.
// ----------------------------------------------------------------------------
module tb_utf8_to_ucs2_decoder;
	import utf8dec_pkg::*;

	localparam int RAND_BYTES   = 900;
	localparam int CALM_TAIL    = 150;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AFTER   = 60;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n;

	utf8dec_in_if  byte_if();
	utf8dec_out_if unit_if();

	utf8_to_ucs2_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_if),
		.unit_stream (unit_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	in_item_t  byte_q[$];
	out_item_t unit_exp_q[$];
	out_item_t pred_unit;
	int        errors = 0;
	int        units_seen = 0;
	int        cyc = 0;

	// decoder state
	logic [PEND_W-1:0] dec_pend;
	logic [UNIT_W-1:0] dec_part;
	logic              dec_halt;

	function automatic bit decode_byte(input in_item_t b, output out_item_t unit);
		logic eos;
		eos  = b.end_of_stream;
		unit = '0;
		if (dec_halt) begin
			if (eos)
				dec_halt = 1'b0;
			return 1'b0;
		end
		if (dec_pend != '0) begin
			dec_part = {dec_part[UNIT_W-7:0], b.in_byte[5:0]};
			dec_pend = dec_pend - PEND_W'(1);
			if (dec_pend == '0) begin
				unit.code_unit = dec_part;
				unit.status    = ST_OK;
				unit.final_res = eos;
				dec_part       = '0;
				return 1'b1;
			end
			if (eos) begin
				dec_pend       = '0;
				dec_part       = '0;
				unit.status    = ST_TRUNC;
				unit.final_res = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		if (b.in_byte < ASCII_LIMIT) begin
			unit.code_unit = {8'h00, b.in_byte};
			unit.status    = ST_OK;
			unit.final_res = eos;
			return 1'b1;
		end
		if ((b.in_byte & LEAD3_MASK) == LEAD3_MASK) begin
			dec_part = {8'h00, b.in_byte & LEAD3_KEEP};
			dec_pend = 2'd2;
		end else if ((b.in_byte & LEAD2_MASK) == LEAD2_MASK) begin
			dec_part = {8'h00, b.in_byte & LEAD2_KEEP};
			dec_pend = 2'd1;
		end else begin
			dec_pend       = '0;
			dec_part       = '0;
			dec_halt       = !eos;
			unit.status    = ST_BAD_LEAD;
			unit.final_res = 1'b1;
			return 1'b1;
		end
		if (eos) begin
			dec_pend       = '0;
			dec_part       = '0;
			unit.status    = ST_TRUNC;
			unit.final_res = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic eos);
		in_item_t it;
		it.in_byte       = b;
		it.end_of_stream = eos;
		byte_q.push_back(it);
	endtask

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return {2'b10, 6'($urandom)};
	endfunction

	// one random symbol; eos lands on its last byte when it closes the stream, but cut-off symbols set eos themselves
	task automatic push_symbol(input logic last);
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			push_byte(8'($urandom_range(0, 127)), last);
		end else if (kind < 55) begin
			push_byte({3'b110, 5'($urandom)}, 1'b0);
			push_byte(cont_byte(), last);
		end else if (kind < 80) begin
			push_byte({3'b111, 5'($urandom)}, 1'b0);
			push_byte(cont_byte(), 1'b0);
			push_byte(cont_byte(), last);
		end else if (kind < 87) begin
			push_byte({2'b10, 6'($urandom)}, last);
		end else if (kind < 94) begin
			push_byte(8'($urandom_range(0, 255)), last);
		end else if (kind < 97) begin
			push_byte({3'b110, 5'($urandom)}, 1'b1);
		end else begin
			push_byte({3'b111, 5'($urandom)}, 1'b0);
			if ($urandom_range(0, 1))
				push_byte(cont_byte(), 1'b1);
			else
				push_byte(cont_byte(), 1'b0);
		end
	endtask

	// byte driver
	int src_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
			byte_if.data  <= '0;
			src_gap       <= 0;
			dec_pend = '0;
			dec_part = '0;
			dec_halt = 1'b0;
		end else begin
			if (byte_if.valid && byte_if.ready) begin
				if (decode_byte(byte_if.data, pred_unit))
					unit_exp_q.push_back(pred_unit);
				void'(byte_q.pop_front());
			end
			if (byte_if.valid && !byte_if.ready) begin
				byte_if.valid <= 1'b1;
			end else if (src_gap > 0) begin
				src_gap       <= src_gap - 1;
				byte_if.valid <= 1'b0;
			end else if (byte_q.size() > CALM_TAIL && (cyc % 256) >= 64 &&
			             $urandom_range(0, 7) == 0) begin
				src_gap       <= $urandom_range(0, 5);
				byte_if.valid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				byte_if.valid <= 1'b1;
				byte_if.data  <= byte_q[0];
			end else begin
				byte_if.valid <= 1'b0;
			end
		end
	end

	// unit monitor and checker
	int  snk_gap = 0;
	int  hold_left = 0;
	bit  held_once = 1'b0;
	out_item_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_if.ready <= 1'b0;
			snk_gap = 0;
			hold_left = 0;
		end else begin
			if (unit_if.valid && unit_if.ready) begin
				units_seen++;
				if (unit_exp_q.size() == 0) begin
					$display("%0t: unexpected unit: expected none, actual %h/%0d/%b",
					         $time, unit_if.data.code_unit, unit_if.data.status,
					         unit_if.data.final_res);
					errors++;
				end else begin
					want = unit_exp_q.pop_front();
					if (unit_if.data.code_unit !== want.code_unit) begin
						$display("%0t: code_unit mismatch: expected %h, actual %h",
						         $time, want.code_unit, unit_if.data.code_unit);
						errors++;
					end
					if (unit_if.data.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
						         $time, want.status, unit_if.data.status);
						errors++;
					end
					if (unit_if.data.final_res !== want.final_res) begin
						$display("%0t: final_res mismatch: expected %b, actual %b",
						         $time, want.final_res, unit_if.data.final_res);
						errors++;
					end
				end
			end
			if (!held_once && units_seen >= HOLD_AFTER) begin
				held_once = 1'b1;
				hold_left = LONG_HOLD;
				unit_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				unit_if.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				unit_if.ready <= 1'b0;
			end else if (byte_q.size() > CALM_TAIL && ((cyc + 128) % 256) >= 64 &&
			             $urandom_range(0, 7) == 0) begin
				snk_gap = $urandom_range(0, 5);
				unit_if.ready <= 1'b0;
			end else begin
				unit_if.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	int idle_cycles = 0;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((byte_if.valid && byte_if.ready) || (unit_if.valid && unit_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int n_sym;
		arst_n = 1'b0;

		// ascii extremes
		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b1);
		// 2-byte sequences, ordinary end of stream
		push_byte(8'hC2, 1'b0);
		push_byte(8'hA9, 1'b1);
		push_byte(8'hDF, 1'b0);
		push_byte(8'hBF, 1'b0);
		// 3-byte sequences, top leads, unchecked continuations
		push_byte(8'hE2, 1'b0);
		push_byte(8'h82, 1'b0);
		push_byte(8'hAC, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hE0, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		// stray continuation, then dropping up to end of stream
		push_byte(8'h80, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'h42, 1'b1);
		// stray continuation on a marked byte, no dropping
		push_byte(8'hBF, 1'b1);
		push_byte(8'h41, 1'b1);
		// cut-off sequences
		push_byte(8'hC3, 1'b1);
		push_byte(8'hE4, 1'b0);
		push_byte(8'h80, 1'b1);

		while (byte_q.size() < RAND_BYTES) begin
			n_sym = $urandom_range(1, 8);
			for (int i = 0; i < n_sym; i++)
				push_symbol(i == n_sym - 1);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || unit_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
